/* design/smx_pkg.sv */
`timescale 1ns / 1ps
package smx_pkg;

  localparam int DEF_STACK_DEPTH  = 1024;
  localparam int DEF_RETURN_DEPTH = 256;
  localparam int DEF_MEMORY_WORDS = 4096;

  localparam logic [7:0] OP_INT  = 8'd0;
  localparam logic [7:0] OP_POP  = 8'd1;
  localparam logic [7:0] OP_PSH  = 8'd2;
  localparam logic [7:0] OP_ADD  = 8'd3;
  localparam logic [7:0] OP_SUB  = 8'd4;
  localparam logic [7:0] OP_LDI  = 8'd5;
  localparam logic [7:0] OP_JMP  = 8'd6;
  localparam logic [7:0] OP_JEQ  = 8'd7;
  localparam logic [7:0] OP_SLT  = 8'd8;
  localparam logic [7:0] OP_STR  = 8'd9;
  localparam logic [7:0] OP_LDR  = 8'd10;
  localparam logic [7:0] OP_HLT  = 8'd11;
  localparam logic [7:0] OP_LDP  = 8'd12;
  localparam logic [7:0] OP_STP  = 8'd13;
  localparam logic [7:0] OP_ICP  = 8'd14;
  localparam logic [7:0] OP_DCP  = 8'd15;
  localparam logic [7:0] OP_SRP  = 8'd16;
  localparam logic [7:0] OP_CALL = 8'd17;
  localparam logic [7:0] OP_RET  = 8'd18;
  localparam logic [7:0] OP_INC  = 8'd19;
  localparam logic [7:0] OP_DEC  = 8'd20;
  localparam logic [7:0] OP_INC2 = 8'd21;
  localparam logic [7:0] OP_DEC2 = 8'd22;
  localparam logic [7:0] OP_DUP  = 8'd23;
  localparam logic [7:0] OP_DRP  = 8'd24;
  localparam logic [7:0] OP_ROT  = 8'd25;
  localparam logic [7:0] OP_NIP  = 8'd26;
  localparam logic [7:0] OP_IMT  = 8'd27;
  localparam logic [7:0] OP_SIZ  = 8'd28;

  localparam logic [63:0] INT_PUTC  = 64'd0;
  localparam logic [63:0] INT_PUTN  = 64'd1;
  localparam logic [63:0] INT_CLR   = 64'd2;
  localparam logic [63:0] INT_SEED  = 64'd3;
  localparam logic [63:0] INT_RANGE = 64'd4;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_OVF     = 3'd3;
  localparam logic [2:0] ST_JRANGE  = 3'd4;
  localparam logic [2:0] ST_JEMPTY  = 3'd5;
  localparam logic [2:0] ST_RNDUF   = 3'd6;
  localparam logic [2:0] ST_CALLOVF = 3'd7;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_CHAR = 2'd1;
  localparam logic [1:0] PK_NUM  = 2'd2;

endpackage

/* design/stack_machine_execute_top.sv */
`timescale 1ns / 1ps
// Stack machine execute unit: one instruction per input request.
// Input channel: in_valid / in_stall with opcode, operand and random_word.
// Output channel: out_valid / out_stall with next_address, status, exit_value,
// print_kind and print_value; exactly one result per request, in order.
// cfg_write / cfg_data load program_length; write it only while idle.
// A request, once accepted, passes two stack reads, execute, write-back
// and the result load; the next request is taken back in idle after the
// result load. A stack rotate stays in write-back until its three entries
// are written, one at a time through the single data stack port. The
// random range interrupt with a nonzero span also passes the bit-serial
// remainder unit. Stacks and data RAM are single-port synchronous memories.
// The output register parts the channels: a new request is taken while a
// finished result still waits under out_stall.
// Reset: synchronous, active high. Afterwards a clearing pass zeroes the
// data RAM, one word a cycle, with in_stall high; configuration writes are
// taken during that pass.
// Stack and return stack contents are undefined until pushed.
module stack_machine_execute_top #(
  parameter int STACK_DEPTH  = smx_pkg::DEF_STACK_DEPTH,
  parameter int RETURN_DEPTH = smx_pkg::DEF_RETURN_DEPTH,
  parameter int MEMORY_WORDS = smx_pkg::DEF_MEMORY_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opcode,
  input  logic [31:0] operand,
  input  logic [63:0] random_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_address,
  output logic [2:0]  status,
  output logic [63:0] exit_value,
  output logic [1:0]  print_kind,
  output logic [63:0] print_value,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int RCW = $clog2(RETURN_DEPTH + 1);
  localparam int MAW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_R1    = 4'd2;
  localparam logic [3:0] S_R2    = 4'd3;
  localparam logic [3:0] S_EX    = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]     state;
  logic [MAW-1:0] clr;

  logic [31:0]    plen;
  logic [63:0]    acc;
  logic [SCW-1:0] sp;
  logic [RCW-1:0] rp;
  logic [MAW-1:0] mp;
  logic [31:0]    ip;
  logic           running;

  logic [7:0]  op;
  logic [31:0] opnd;
  logic [63:0] rnd;
  logic [63:0] top, sec, pw, sw;
  logic [31:0] rtop;

  logic [63:0] ds_mem [STACK_DEPTH];
  logic [31:0] rs_mem [RETURN_DEPTH];
  logic [63:0] dm_mem [MEMORY_WORDS];
  logic [63:0] ds_q, dm_q;
  logic [31:0] rs_q;
  logic [SAW-1:0] ds_addr;
  logic [63:0]    ds_wd;
  logic           ds_we;
  logic [RAW-1:0] rs_addr;
  logic           rs_we;
  logic [MAW-1:0] dm_addr;
  logic [63:0]    dm_wd;
  logic           dm_we;

  logic [2:0][SAW-1:0] wa_q;
  logic [2:0][63:0]    wd_q;
  logic [1:0]          wn_q;
  logic [1:0]          wi;
  logic                dmw_q;
  logic [MAW-1:0]      dma_q;
  logic [63:0]         dmd_q;
  logic                rsw_q;
  logic [RAW-1:0]      rsa_q;
  logic [31:0]         rsd_q;
  logic                div_pend;

  logic [31:0] r_next;
  logic [2:0]  r_status;
  logic [63:0] r_exit;
  logic [1:0]  r_pkind;
  logic [63:0] r_pval;

  logic [63:0] dq, rem, span, base;
  logic [5:0]  cnt;
  logic [64:0] rem_sh, rem_diff;

  logic [SCW-1:0] sp_m1, sp_m2, sp_m3;
  logic [RCW-1:0] rp_m1;
  logic [MAW-1:0] saddr_r1;

  logic [2:0]          x_st;
  logic [31:0]         x_next;
  logic [63:0]         x_acc, x_exit, x_pval;
  logic [1:0]          x_pk;
  logic [SCW-1:0]      x_sp;
  logic [RCW-1:0]      x_rp;
  logic [MAW-1:0]      x_mp;
  logic [2:0][SAW-1:0] x_wa;
  logic [2:0][63:0]    x_wd;
  logic [1:0]          x_wn;
  logic                x_dmw;
  logic [MAW-1:0]      x_dma;
  logic                x_rsw;
  logic                x_div;
  logic                x_running;
  logic [63:0]         x_span, x_base;
  logic [63:0]         thr;
  logic                wr_done;

  function automatic logic [MAW-1:0] ram_index(input logic [63:0] a);
    ram_index = (a >= 64'(MEMORY_WORDS)) ? MAW'(MEMORY_WORDS - 1) : a[MAW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign sp_m1 = sp - SCW'(1);
  assign sp_m2 = sp - SCW'(2);
  assign sp_m3 = sp - SCW'(3);
  assign rp_m1 = rp - RCW'(1);
  assign saddr_r1 = (sp == '0) ? '0 : ram_index(ds_q);
  assign thr = ds_q;
  assign wr_done = ({1'b0, wi} + 3'd1 >= {1'b0, wn_q});

  always_comb begin
    ds_addr = '0;
    ds_we   = 1'b0;
    ds_wd   = wd_q[wi];
    rs_addr = rp_m1[RAW-1:0];
    rs_we   = 1'b0;
    dm_addr = mp;
    dm_we   = 1'b0;
    dm_wd   = dmd_q;
    unique case (state)
      S_CLEAR: begin
        dm_addr = clr;
        dm_we   = 1'b1;
        dm_wd   = '0;
      end
      S_IDLE: ds_addr = sp_m1[SAW-1:0];
      S_R1: begin
        ds_addr = sp_m2[SAW-1:0];
        dm_addr = saddr_r1;
      end
      S_R2: ds_addr = sp_m3[SAW-1:0];
      S_WR: begin
        ds_addr = wa_q[wi];
        ds_we   = ({1'b0, wi} < {1'b0, wn_q});
        rs_addr = rsa_q;
        rs_we   = rsw_q && (wi == 2'd0);
        dm_addr = dma_q;
        dm_we   = dmw_q && (wi == 2'd0);
      end
      S_EX, S_DIV, S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ds_we) ds_mem[ds_addr] <= ds_wd;
    ds_q <= ds_mem[ds_addr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_addr] <= rsd_q;
    rs_q <= rs_mem[rs_addr];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dm_mem[dm_addr] <= dm_wd;
    dm_q <= dm_mem[dm_addr];
  end

  always_comb begin
    x_st      = smx_pkg::ST_RUN;
    x_next    = ip + 32'd1;
    x_acc     = acc;
    x_exit    = '0;
    x_pk      = smx_pkg::PK_NONE;
    x_pval    = '0;
    x_sp      = sp;
    x_rp      = rp;
    x_mp      = mp;
    x_wa      = '0;
    x_wd      = '0;
    x_wn      = 2'd0;
    x_dmw     = 1'b0;
    x_dma     = (sp == '0) ? '0 : ram_index(top);
    x_rsw     = 1'b0;
    x_div     = 1'b0;
    x_running = running;
    if (sec > top) begin
      x_base = top;
      x_span = sec - top + 64'd1;
    end else begin
      x_base = sec;
      x_span = top - sec + 64'd1;
    end
    unique case (op) inside
      smx_pkg::OP_INT: begin
        if (acc == smx_pkg::INT_PUTC || acc == smx_pkg::INT_PUTN) begin
          x_pk = smx_pkg::PK_CHAR;
          if (sp != '0) begin
            x_sp   = sp_m1;
            x_pval = top;
            if (acc == smx_pkg::INT_PUTN) x_pk = smx_pkg::PK_NUM;
          end
        end else if (acc == smx_pkg::INT_CLR) begin
          x_sp = '0;
        end else if (acc == smx_pkg::INT_SEED) begin
          if (sp != '0) x_sp = sp_m1;
        end else if (acc == smx_pkg::INT_RANGE) begin
          if (sp < SCW'(2)) begin
            x_st = smx_pkg::ST_RNDUF;
          end else begin
            x_sp = sp_m2;
            if (x_span == '0) x_acc = rnd;
            else x_div = 1'b1;
          end
        end
      end
      smx_pkg::OP_POP: begin
        if (sp == '0) x_acc = '0;
        else begin
          x_sp  = sp_m1;
          x_acc = top;
        end
      end
      smx_pkg::OP_PSH: begin
        if (sp >= SCW'(STACK_DEPTH)) x_st = smx_pkg::ST_OVF;
        else begin
          x_wn    = 2'd1;
          x_wa[0] = sp[SAW-1:0];
          x_wd[0] = acc;
          x_sp    = sp + SCW'(1);
        end
      end
      smx_pkg::OP_ADD, smx_pkg::OP_SUB: begin
        x_wn = 2'd1;
        if (sp == '0) begin
          x_wa[0] = '0;
          x_wd[0] = (op == smx_pkg::OP_ADD) ? acc : ~acc;
          x_sp    = SCW'(1);
        end else begin
          x_wa[0] = sp_m1[SAW-1:0];
          x_wd[0] = (op == smx_pkg::OP_ADD) ? top + acc : top - acc;
        end
      end
      smx_pkg::OP_LDI: begin
        x_acc  = {32'd0, opnd};
        x_next = ip + 32'd5;
      end
      smx_pkg::OP_JMP: begin
        if (opnd > plen) x_st = smx_pkg::ST_JRANGE;
        else x_next = opnd;
      end
      smx_pkg::OP_JEQ: begin
        if (sp == '0) x_st = smx_pkg::ST_JEMPTY;
        else if (acc == top) begin
          if (opnd > plen) x_st = smx_pkg::ST_JRANGE;
          else x_next = opnd;
        end else x_next = ip + 32'd5;
      end
      smx_pkg::OP_SLT: x_acc = {63'd0, (sp != '0) && (top < acc)};
      smx_pkg::OP_STR: x_dmw = 1'b1;
      smx_pkg::OP_LDR: x_acc = sw;
      smx_pkg::OP_HLT: begin
        x_st   = smx_pkg::ST_HALT;
        x_exit = acc;
      end
      smx_pkg::OP_LDP: x_acc = pw;
      smx_pkg::OP_STP: begin
        x_dmw = 1'b1;
        x_dma = mp;
      end
      smx_pkg::OP_ICP: x_mp = (mp >= MAW'(MEMORY_WORDS - 1)) ? '0 : mp + MAW'(1);
      smx_pkg::OP_DCP: x_mp = (mp == '0) ? MAW'(MEMORY_WORDS - 1) : mp - MAW'(1);
      smx_pkg::OP_SRP: x_mp = ram_index(acc);
      smx_pkg::OP_CALL: begin
        if (rp >= RCW'(RETURN_DEPTH)) x_st = smx_pkg::ST_CALLOVF;
        else if (opnd > plen) x_st = smx_pkg::ST_JRANGE;
        else begin
          x_rsw  = 1'b1;
          x_rp   = rp + RCW'(1);
          x_next = opnd;
        end
      end
      smx_pkg::OP_RET: begin
        if (rp == '0) begin
          x_st   = smx_pkg::ST_HALT;
          x_exit = acc;
        end else begin
          x_rp   = rp_m1;
          x_next = rtop;
        end
      end
      smx_pkg::OP_INC, smx_pkg::OP_INC2: x_acc = acc + 64'd1;
      smx_pkg::OP_DEC, smx_pkg::OP_DEC2: x_acc = acc - 64'd1;
      smx_pkg::OP_DUP: begin
        if (sp >= SCW'(STACK_DEPTH)) x_st = smx_pkg::ST_OVF;
        else if (sp != '0) begin
          x_wn    = 2'd1;
          x_wa[0] = sp[SAW-1:0];
          x_wd[0] = top;
          x_sp    = sp + SCW'(1);
        end
      end
      smx_pkg::OP_DRP: begin
        if (sp != '0) x_sp = sp_m1;
      end
      smx_pkg::OP_ROT: begin
        if (sp >= SCW'(3)) begin
          x_wn    = 2'd3;
          x_wa[0] = sp_m3[SAW-1:0];
          x_wd[0] = top;
          x_wa[1] = sp_m2[SAW-1:0];
          x_wd[1] = thr;
          x_wa[2] = sp_m1[SAW-1:0];
          x_wd[2] = sec;
        end
      end
      smx_pkg::OP_NIP: begin
        if (sp >= SCW'(2)) begin
          x_wn    = 2'd1;
          x_wa[0] = sp_m2[SAW-1:0];
          x_wd[0] = top;
          x_sp    = sp_m1;
        end
      end
      smx_pkg::OP_IMT: x_acc = {63'd0, sp != '0};
      smx_pkg::OP_SIZ: x_acc = 64'(sp);
      default: ;
    endcase
    if (!running || x_st != smx_pkg::ST_RUN) begin
      x_acc     = acc;
      x_sp      = sp;
      x_rp      = rp;
      x_mp      = mp;
      x_wn      = 2'd0;
      x_dmw     = 1'b0;
      x_rsw     = 1'b0;
      x_div     = 1'b0;
      x_next    = ip;
      x_running = 1'b0;
      if (!running) begin
        x_st   = smx_pkg::ST_END;
        x_exit = '0;
        x_pk   = smx_pkg::PK_NONE;
        x_pval = '0;
      end
    end else if (x_next == plen) begin
      x_st      = smx_pkg::ST_END;
      x_running = 1'b0;
    end
  end

  assign rem_sh   = {rem, dq[63]};
  assign rem_diff = rem_sh - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      plen      <= '0;
      acc       <= '0;
      sp        <= '0;
      rp        <= '0;
      mp        <= '0;
      ip        <= '0;
      running   <= 1'b1;
      out_valid <= 1'b0;
      div_pend  <= 1'b0;
      wi        <= '0;
    end else begin
      if (cfg_write) plen <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + MAW'(1);
          if (clr == MAW'(MEMORY_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            opnd  <= operand;
            rnd   <= random_word;
            state <= S_R1;
          end
        end
        S_R1: begin
          top   <= ds_q;
          pw    <= dm_q;
          rtop  <= rs_q;
          state <= S_R2;
        end
        S_R2: begin
          sec   <= ds_q;
          sw    <= dm_q;
          state <= S_EX;
        end
        S_EX: begin
          acc      <= x_acc;
          sp       <= x_sp;
          rp       <= x_rp;
          mp       <= x_mp;
          ip       <= x_next;
          running  <= x_running;
          wa_q     <= x_wa;
          wd_q     <= x_wd;
          wn_q     <= x_wn;
          dmw_q    <= x_dmw;
          dma_q    <= x_dma;
          dmd_q    <= acc;
          rsw_q    <= x_rsw;
          rsa_q    <= rp[RAW-1:0];
          rsd_q    <= ip + 32'd5;
          r_next   <= x_next;
          r_status <= x_st;
          r_exit   <= x_exit;
          r_pkind  <= x_pk;
          r_pval   <= x_pval;
          wi       <= '0;
          div_pend <= x_div;
          dq       <= rnd;
          rem      <= '0;
          cnt      <= '0;
          span     <= x_span;
          base     <= x_base;
          state    <= x_div ? S_DIV : S_WR;
        end
        S_DIV: begin
          dq  <= {dq[62:0], 1'b0};
          rem <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_WR;
        end
        S_WR: begin
          if (div_pend) begin
            acc      <= rem + base;
            div_pend <= 1'b0;
          end
          wi <= wi + 2'd1;
          if (wr_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            next_address <= r_next;
            status       <= r_status;
            exit_value   <= r_exit;
            print_kind   <= r_pkind;
            print_value  <= r_pval;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_rp_bound: assert property (@(posedge clk) disable iff (rst)
    rp <= RCW'(RETURN_DEPTH))
    else $error("return count beyond depth");

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    !running |=> !running)
    else $error("machine restarted without reset");

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && r_status >= smx_pkg::ST_HALT && r_status != smx_pkg::ST_END)
      |-> (!ds_we && !dm_we && !rs_we))
    else $error("state written on halt or error");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (in_stall && dm_we))
    else $error("request taken during clearing pass");

endmodule
